// File: rtl/core/mrltd_pkg.sv
package mrltd_pkg;

   // ascii codes the decoder reacts to
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL    = 8'h0A;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 16;
   // count*10 + 9 fits here for any 16-bit count
   localparam int unsigned PROD_W  = COUNT_W + 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic               in_run;
      logic [BYTE_W-1:0]  marker;
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } run_state_type;

   typedef struct packed {
      logic               valid;
      logic [BYTE_W-1:0]  out_char;
      logic [COUNT_W-1:0] repeat_res;
      logic               count_saturated;
      logic               format_error;
   } result_type;

endpackage

// File: rtl/core/mrltd_step.sv
module mrltd_step (
   input  logic [mrltd_pkg::BYTE_W-1:0] in_byte,
   input  mrltd_pkg::run_state_type     run_cur,
   output mrltd_pkg::run_state_type     run_next,
   output mrltd_pkg::result_type        res
);

   logic                               is_digit;
   logic [mrltd_pkg::PROD_W-1:0]       count_ext;
   logic [mrltd_pkg::PROD_W-1:0]       count_next;

   assign is_digit  = (in_byte >= mrltd_pkg::CH_ZERO) && (in_byte <= mrltd_pkg::CH_NINE);
   assign count_ext = {{(mrltd_pkg::PROD_W - mrltd_pkg::COUNT_W){1'b0}}, run_cur.count};
   // count*10 as two shifts and an add, then the digit value
   assign count_next = (count_ext << 3) + (count_ext << 1)
                     + {{(mrltd_pkg::PROD_W - 4){1'b0}}, in_byte[3:0] - 4'd0};

   always_comb begin
      run_next = run_cur;
      res      = '0;
      if (!run_cur.in_run) begin
         if (in_byte == mrltd_pkg::CH_ZERO || in_byte == mrltd_pkg::CH_ONE ||
             in_byte == mrltd_pkg::CH_SPACE || in_byte == mrltd_pkg::CH_NL) begin
            res.valid      = 1'b1;
            res.out_char   = in_byte;
            res.repeat_res = mrltd_pkg::COUNT_W'(1);
         end else begin
            run_next.in_run   = 1'b1;
            run_next.marker   = in_byte;
            run_next.count    = '0;
            run_next.overflow = 1'b0;
         end
      end else if (in_byte == run_cur.marker) begin
         // closing marker, wins over the digit meaning
         run_next                = '0;
         res.valid               = (run_cur.count != '0);
         res.out_char            = (run_cur.marker == mrltd_pkg::CH_MINUS) ?
                                   mrltd_pkg::CH_ZERO : mrltd_pkg::CH_ONE;
         res.repeat_res          = run_cur.count;
         res.count_saturated     = run_cur.overflow;
      end else if (is_digit) begin
         if (count_next > {{(mrltd_pkg::PROD_W - mrltd_pkg::COUNT_W){1'b0}},
                           mrltd_pkg::COUNT_MAX}) begin
            run_next.count    = mrltd_pkg::COUNT_MAX;
            run_next.overflow = 1'b1;
         end else begin
            run_next.count = count_next[mrltd_pkg::COUNT_W-1:0];
         end
      end else begin
         run_next         = '0;
         res.valid        = 1'b1;
         res.format_error = 1'b1;
      end
   end

endmodule

// File: rtl/core/marked_run_length_text_decoder.sv
// each req_ byte is held in the input register, its result in the result register
// throughput: one byte per cycle unless rsp_ stalls; the run state is registered
// a run of bytes that opens or extends a run produces no rsp_ beat
// reset: synchronous, active high; clears the run state and both valid flags
// after reset the block is idle and ready at once, no clearing pass
module marked_run_length_text_decoder (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_char, [23:8] repeat_res
   output logic [1:0]  rsp_tuser    // [0] count_saturated, [1] format_error
);

   // input register stage
   logic                            in_valid_ff, in_valid_in;
   logic [mrltd_pkg::BYTE_W-1:0]    in_byte_ff, in_byte_in;

   // run state carried from byte to byte
   mrltd_pkg::run_state_type        run_ff, run_in;

   // result register
   logic                            out_valid_ff, out_valid_in;
   mrltd_pkg::result_type           out_ff, out_in;

   mrltd_pkg::run_state_type        step_next;
   mrltd_pkg::result_type           step_res;

   logic                            advance;

   // decode of the held byte against the current run state
   mrltd_step u_step (
      .in_byte  (in_byte_ff),
      .run_cur  (run_ff),
      .run_next (step_next),
      .res      (step_res)
   );

   // the held byte moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
   end

   always_comb begin
      run_in = run_ff;
      if (advance) begin
         run_in = step_next;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         // only a result beat replaces the held payload
         out_valid_in = step_res.valid;
         if (step_res.valid) begin
            out_in = step_res;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         run_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         run_ff       <= run_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.repeat_res, out_ff.out_char};
   assign rsp_tuser  = {out_ff.format_error, out_ff.count_saturated};

   // an error beat carries no character, no count and no saturation flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> (rsp_tdata == '0) && !rsp_tuser[0])
      else $error("error beat with payload");

   // every good beat writes at least one character
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[23:8] != '0)
      else $error("good beat with zero repeat");

   // a saturated count is always clipped to the top value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[23:8] == mrltd_pkg::COUNT_MAX)
      else $error("saturated beat not clipped");

   // a run never holds a nonzero count once it is closed
   assert property (@(posedge clock) disable iff (reset)
      !run_ff.in_run |-> (run_ff.count == '0) && !run_ff.overflow)
      else $error("idle state keeps run count");

endmodule

// File: tb/marked_run_length_text_decoder_tb.sv
module marked_run_length_text_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STIM_BYTES  = 1650;
   // no beat on either side for this long means the block is hung
   localparam int unsigned STALL_LIMIT = 2000;
   // extra margin for the final drain
   localparam int unsigned TAIL_CYCLES = 10;

   // one decoded beat as it leaves the block
   typedef struct packed {
      logic [mrltd_pkg::BYTE_W-1:0]  out_char;
      logic [mrltd_pkg::COUNT_W-1:0] repeat_res;
      logic                          count_saturated;
      logic                          format_error;
   } decoded_beat_type;

   // tracks the run state and holds the decoded beats still owed
   class run_decode_board;
      bit                            in_run;
      logic [mrltd_pkg::BYTE_W-1:0]  marker;
      logic [mrltd_pkg::COUNT_W-1:0] count;
      bit                            overflow;
      decoded_beat_type              owed_q[$];
      int unsigned                   errors;

      task report(input string what);
         $display("%0t ns  mismatch: %s", $time, what);
         errors++;
      endtask

      task clear_run();
         in_run   = 1'b0;
         marker   = '0;
         count    = '0;
         overflow = 1'b0;
      endtask

      // update the run state for one accepted input byte
      task note_byte(input logic [mrltd_pkg::BYTE_W-1:0] b);
         int unsigned      scaled;
         decoded_beat_type beat;
         if (!in_run) begin
            if (b == mrltd_pkg::CH_ZERO || b == mrltd_pkg::CH_ONE ||
                b == mrltd_pkg::CH_SPACE || b == mrltd_pkg::CH_NL) begin
               beat = '{b, 16'd1, 1'b0, 1'b0};
               owed_q.push_back(beat);
            end else begin
               in_run   = 1'b1;
               marker   = b;
               count    = '0;
               overflow = 1'b0;
            end
         end else if (b == marker) begin
            // closing marker wins over the digit meaning
            beat = '{(marker == mrltd_pkg::CH_MINUS) ? mrltd_pkg::CH_ZERO : mrltd_pkg::CH_ONE,
                     count, overflow, 1'b0};
            if (count != '0)
               owed_q.push_back(beat);
            clear_run();
         end else if (b >= mrltd_pkg::CH_ZERO && b <= mrltd_pkg::CH_NINE) begin
            scaled = count * 10 + (b - mrltd_pkg::CH_ZERO);
            if (scaled > mrltd_pkg::COUNT_MAX) begin
               count    = mrltd_pkg::COUNT_MAX;
               overflow = 1'b1;
            end else begin
               count = scaled[mrltd_pkg::COUNT_W-1:0];
            end
         end else begin
            clear_run();
            beat = '{8'h00, 16'h0000, 1'b0, 1'b1};
            owed_q.push_back(beat);
         end
      endtask

      task check_beat(input decoded_beat_type got);
         decoded_beat_type want;
         if (owed_q.size() == 0) begin
            report($sformatf("unexpected beat char %h rep %0d", got.out_char,
                             got.repeat_res));
         end else begin
            want = owed_q.pop_front();
            if (got.out_char !== want.out_char)
               report($sformatf("out_char %h, want %h", got.out_char, want.out_char));
            if (got.repeat_res !== want.repeat_res)
               report($sformatf("repeat_res %0d, want %0d", got.repeat_res,
                                want.repeat_res));
            if (got.count_saturated !== want.count_saturated)
               report($sformatf("count_saturated %b, want %b", got.count_saturated,
                                want.count_saturated));
            if (got.format_error !== want.format_error)
               report($sformatf("format_error %b, want %b", got.format_error,
                                want.format_error));
         end
      endtask
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [7:0] out_char, [23:8] repeat_res
   logic [1:0]  rsp_tuser;            // [0] count_saturated, [1] format_error

   run_decode_board board;

   int unsigned bytes_sent;
   int unsigned burst_left;
   int unsigned quiet_cycles;

   marked_run_length_text_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // drive one byte and hold it until the block takes the beat;
   // the sender runs in bursts with random gaps between them
   task automatic push_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      board.note_byte(b);
      bytes_sent++;
   endtask

   // stop sending until every owed beat has come out
   task automatic drain_pause();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.owed_q.size() != 0);
   endtask

   // a well-formed run with random marker and digits, sometimes broken
   task automatic send_run();
      logic [7:0]  mark;
      logic [7:0]  dig;
      int unsigned ndig;
      int unsigned break_at;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         mark = mrltd_pkg::CH_MINUS;
      else if (pick < 6)
         mark = 8'h2B;   // plus sign
      else begin
         do mark = 8'($urandom_range(0, 255));
         while (mark == mrltd_pkg::CH_ZERO || mark == mrltd_pkg::CH_ONE ||
                mark == mrltd_pkg::CH_SPACE || mark == mrltd_pkg::CH_NL);
      end
      ndig     = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
      // a stray byte lands somewhere in about one run in eight
      break_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ndig) : ndig + 1;
      push_byte(mark);
      for (int unsigned i = 0; i < ndig; i++) begin
         if (i == break_at)
            push_byte(8'($urandom_range(0, 255)));
         dig = 8'(mrltd_pkg::CH_ZERO + $urandom_range(0, 9));
         if (dig == mark)
            dig = (mark == mrltd_pkg::CH_NINE) ? mrltd_pkg::CH_ZERO : 8'(mark + 1);
         push_byte(dig);
      end
      if (break_at == ndig)
         push_byte(8'($urandom_range(0, 255)));
      push_byte(mark);
   endtask

   task automatic send_noise();
      logic [7:0] pass_set [4];
      pass_set = '{mrltd_pkg::CH_ZERO, mrltd_pkg::CH_ONE, mrltd_pkg::CH_SPACE,
                   mrltd_pkg::CH_NL};
      if ($urandom_range(0, 1) == 0)
         push_byte(pass_set[2'($urandom_range(0, 3))]);
      else
         push_byte(8'($urandom_range(0, 255)));
   endtask

   // receiver: ready pattern switches among a few modes every so often
   int unsigned ready_mode;
   int unsigned mode_left;
   int unsigned ready_phase;

   always @(posedge clock) begin
      decoded_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[7:0], rsp_tdata[23:8], rsp_tuser[0], rsp_tuser[1]};
         board.check_beat(got);
      end
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      ready_phase++;
      case (ready_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 99) < 60);
         end
         2: begin
            // short windows of ready between long stalls
            rsp_tready <= ((ready_phase % 16) < 4);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 9) != 0);
         end
      endcase
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("marked_run_length_text_decoder_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [7:0] directed [$];
      bit         paused;
      board        = new();
      board.clear_run();
      bytes_sent   = 0;
      burst_left   = 0;
      quiet_cycles = 0;
      ready_mode   = 0;
      mode_left    = 0;
      ready_phase  = 0;
      paused       = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // pass-through characters
      directed = {mrltd_pkg::CH_ZERO, mrltd_pkg::CH_ONE, mrltd_pkg::CH_SPACE,
                  mrltd_pkg::CH_NL};
      // minus run with the largest count that does not clip
      directed = {directed, mrltd_pkg::CH_MINUS, "6", "5", "5", "3", "5",
                  mrltd_pkg::CH_MINUS};
      // all-ones marker, count clips and sets the saturation flag
      directed = {directed, 8'hFF, "9", "9", "9", "9", "9", 8'hFF};
      // digit as marker: the same digit closes instead of counting
      directed = {directed, "7", "3", "7"};
      // all-zero marker with an empty run gives nothing
      directed = {directed, 8'h00, 8'h00};
      // stray letter inside a run
      directed = {directed, "a", "5", "b"};
      foreach (directed[i])
         push_byte(directed[i]);

      while (bytes_sent < STIM_BYTES) begin
         if (!paused && bytes_sent >= STIM_BYTES / 2) begin
            drain_pause();
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) < 7)
            send_run();
         else
            send_noise();
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.owed_q.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.owed_q.size() != 0)
         board.report($sformatf("%0d beats never came out", board.owed_q.size()));

      if (board.errors == 0)
         $display("marked_run_length_text_decoder_tb: clean");
      else
         $display("marked_run_length_text_decoder_tb: errors");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/mrltd_pkg.sv
rtl/core/mrltd_step.sv
rtl/core/marked_run_length_text_decoder.sv
tb/marked_run_length_text_decoder_tb.sv
